### rtl/icwm_pkg.sv
// Shared types, constants and adjacency helpers for the weighted cut minimum block.
package icwm_pkg;

   localparam int VertexCount = 8;
   localparam int VertexBits  = 3;
   localparam int CutCount    = 128;
   localparam int CutBits     = 7;
   localparam int WeightBits  = 16;
   localparam int SumBits     = 20;
   localparam int CutSumBits  = 40;
   localparam int TotalBits   = 19;
   localparam int BestBits    = 43;
   localparam int AdjBits     = 64;
   localparam int RatioBits   = 8;
   localparam int DivBits     = 28;
   localparam int CsrIndexBits = 2;

   localparam logic [CsrIndexBits-1:0] CSR_ADJACENCY   = 2'd0;
   localparam logic [CsrIndexBits-1:0] CSR_NUMERATOR   = 2'd1;
   localparam logic [CsrIndexBits-1:0] CSR_DENOMINATOR = 2'd2;

   typedef enum logic [1:0] {
      CMD_LOAD   = 2'd0,
      CMD_RECALC = 2'd1,
      CMD_PROBE  = 2'd2,
      CMD_APPLY  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_SRC_EMPTY = 2'd1,
      ST_SAME      = 2'd2,
      ST_DST_FULL  = 2'd3
   } status_type;

   typedef struct packed {
      cmd_type                 cmd;
      logic [VertexBits-1:0]   source_vertex;
      logic [VertexBits-1:0]   dest_vertex;
      logic [WeightBits-1:0]   weight;
   } req_type;

   typedef struct packed {
      logic [CutSumBits-1:0]   min_cut;
      logic [CutSumBits-1:0]   probe_value;
      logic                    feasible;
      logic                    move_feasible;
      logic [TotalBits-1:0]    total_weight;
      status_type              status;
   } rsp_type;

   typedef struct packed {
      logic [CutSumBits-1:0]                   cut_sum;
      logic [VertexCount-1:0][SumBits-1:0]     nsum;
   } row_type;

   // Neighbors of v, either matrix bit counts, diagonal ignored.
   function automatic logic [VertexCount-1:0] adj_row(input logic [AdjBits-1:0] adj,
                                                      input logic [VertexBits-1:0] v);
      logic [VertexCount-1:0] r;
      r = '0;
      for (int u = 0; u < VertexCount; u++) begin
         r[u] = (adj[{v, VertexBits'(u)}] | adj[{VertexBits'(u), v}]) &&
                (VertexBits'(u) != v);
      end
      return r;
   endfunction

   // Side of each vertex for a cut; vertex 0 always on side 0.
   function automatic logic [VertexCount-1:0] side_vec(input logic [CutBits-1:0] cut);
      return {cut, 1'b0};
   endfunction

endpackage

### rtl/icwm_div.sv
// Restoring divider, one quotient bit per cycle, for the degree bound.
module icwm_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [icwm_pkg::DivBits-1:0]  dividend,
   input  logic [icwm_pkg::RatioBits-1:0] divisor,
   output logic                          done,
   output logic [icwm_pkg::DivBits-1:0]  quotient
);
   import icwm_pkg::*;

   logic [DivBits-1:0]   quot_ff, quot_in;
   logic [RatioBits-1:0] rem_ff, rem_in;
   logic [4:0]           cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [RatioBits:0]   trial;
   logic                 fits;

   always_comb begin
      trial   = {rem_ff, quot_ff[DivBits-1]};
      fits    = trial >= {1'b0, divisor};
      quot_in = quot_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quot_in = dividend;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? RatioBits'(trial - {1'b0, divisor}) : trial[RatioBits-1:0];
         quot_in = {quot_ff[DivBits-2:0], fits};
         cnt_in  = cnt_ff + 5'd1;
         if (cnt_ff == 5'(DivBits - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

### rtl/icwm_row_mem.sv
// Per-cut row store: cut sum and same-side neighbor sums, with row valid bits.
module icwm_row_mem (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [icwm_pkg::CutBits-1:0]  rd_addr,
   output icwm_pkg::row_type             rd_data,
   input  logic                          wr_en,
   input  logic [icwm_pkg::CutBits-1:0]  wr_addr,
   input  icwm_pkg::row_type             wr_data
);
   import icwm_pkg::*;

   row_type              mem_ff [CutCount];
   row_type              rd_ff;
   logic                 rd_valid_ff;
   logic [CutCount-1:0]  valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_ff <= mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= valid_ff[rd_addr];
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   // Unwritten rows read as zero.
   assign rd_data = rd_valid_ff ? rd_ff : '0;

endmodule

### rtl/icwm_row_unit.sv
// Row update for a unit move: probed cut value and the updated row.
module icwm_row_unit (
   input  icwm_pkg::row_type                 row,
   input  logic [icwm_pkg::CutBits-1:0]      cut,
   input  logic [icwm_pkg::VertexBits-1:0]   src,
   input  logic [icwm_pkg::VertexBits-1:0]   dst,
   input  logic [icwm_pkg::AdjBits-1:0]      adj,
   output logic [icwm_pkg::BestBits-1:0]     probe_value,
   output icwm_pkg::row_type                 new_row
);
   import icwm_pkg::*;

   logic [VertexCount-1:0] adj_i, adj_j, sides;
   logic                   dec;
   logic [BestBits-1:0]    val;

   always_comb begin
      adj_i = adj_row(adj, src);
      adj_j = adj_row(adj, dst);
      sides = side_vec(cut);
      dec   = adj_i[dst] && (sides[src] == sides[dst]);
      val   = BestBits'(row.cut_sum) - BestBits'(row.nsum[src]) + BestBits'(row.nsum[dst])
              - BestBits'(dec);
      new_row.cut_sum = val[CutSumBits-1:0];
      for (int u = 0; u < VertexCount; u++) begin
         new_row.nsum[u] = row.nsum[u]
            - SumBits'(adj_i[u] && (sides[u] == sides[src]))
            + SumBits'(adj_j[u] && (sides[u] == sides[dst]));
      end
   end

   assign probe_value = val;

endmodule

### rtl/incremental_weighted_cut_minimum.sv
// Top level of the weighted same-side cut minimum block on an 8-vertex graph.
// The block keeps vertex weights and, for each of the 128 cuts with vertex 0 on
// side 0, the same-side weighted edge sum and per-vertex same-side neighbor sums
// in a 128-row store. One request is worked at a time and req_stall stays high
// meanwhile. Load writes the weight and responds; probe and apply sweep the row
// store through the shared row update unit at one cut per cycle; recompute runs
// the bit-serial divider for the degree bound, then works each cut vertex by
// vertex through the single 16x20 multiplier. A finished response waits in the
// output register; the next request is taken as soon as the block is back in
// idle. Configuration is accepted in every cycle.
module incremental_weighted_cut_minimum (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  icwm_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output icwm_pkg::rsp_type                 rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [icwm_pkg::CsrIndexBits-1:0] csr_index,
   input  logic [icwm_pkg::AdjBits-1:0]      csr_data
);
   import icwm_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE      = 6'b000001,
      S_DIV_START = 6'b000010,
      S_DIV_WAIT  = 6'b000100,
      S_RECALC    = 6'b001000,
      S_WALK      = 6'b010000,
      S_RESP      = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [AdjBits-1:0]   adj_ff;
   logic [RatioBits-1:0] num_ff, den_ff;

   // kept state
   logic [VertexCount-1:0][WeightBits-1:0] weight_ff, weight_in;
   logic [VertexCount-1:0][SumBits-1:0]    nw_ff, nw_in;
   logic [SumBits-1:0]                     bound_ff, bound_in;
   logic [SumBits-1:0]                     total_ff, total_in;
   logic [CutSumBits-1:0]                  min_ff, min_in;

   // request context
   cmd_type               cmd_ff, cmd_in;
   logic [VertexBits-1:0] src_ff, src_in, dst_ff, dst_in;
   status_type            status_ff, status_in;

   // sequencing and the shared datapath
   logic [CutBits:0]                       cnt_ff, cnt_in;
   logic [3:0]                             step_ff, step_in;
   logic [CutSumBits-1:0]                  acc_ff, acc_in;
   logic [35:0]                            prod_ff, prod_in;
   logic [VertexCount-1:0][SumBits-1:0]    msum_ff, msum_in;
   logic [BestBits-1:0]                    best_ff, best_in;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   // row store and units
   logic [CutBits-1:0] wr_addr;
   logic               wr_en;
   row_type            rd_row, wr_row, walk_row;
   logic [BestBits-1:0] walk_value, cand;
   logic [CutBits-1:0] walk_cut;
   logic               div_start, div_done;
   logic [DivBits-1:0] div_quot;
   logic [RatioBits-1:0] den_eff;
   logic [DivBits-1:0] div_dividend;

   logic                 req_take;
   status_type           chk_status;
   logic [VertexCount-1:0] adj_i, adj_j, adj_k, sides_k, adj_v;
   logic [VertexBits-1:0]  k_idx;
   logic [CutSumBits-1:0]  recalc_sum;
   logic                   first_cand, take_cand;
   logic                   feas_now, feas_after;
   logic [17:0]            av;
   logic [21:0]            dv;
   logic [TotalBits-1:0]   sum_w;
   logic [SumBits-1:0]     nw_acc;
   logic [CutSumBits-1:0]  probe_clamped;

   icwm_row_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (cnt_ff[CutBits-1:0]),
      .rd_data (rd_row),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_row)
   );

   icwm_row_unit u_row (
      .row         (rd_row),
      .cut         (walk_cut),
      .src         (src_ff),
      .dst         (dst_ff),
      .adj         (adj_ff),
      .probe_value (walk_value),
      .new_row     (walk_row)
   );

   icwm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (den_eff),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign csr_ready    = 1'b1;
   assign req_stall    = state_ff != S_IDLE;
   assign req_take     = req_valid && !req_stall;
   assign den_eff      = (den_ff == '0) ? RatioBits'(1) : den_ff;
   assign div_dividend = DivBits'(num_ff) * DivBits'(total_ff);
   assign div_start    = state_ff == S_DIV_START;
   assign walk_cut     = CutBits'(cnt_ff - 1'b1);

   // Validity checks of a move, in priority order.
   always_comb begin
      if (weight_ff[req_data.source_vertex] == '0) begin
         chk_status = ST_SRC_EMPTY;
      end else if (req_data.source_vertex == req_data.dest_vertex) begin
         chk_status = ST_SAME;
      end else if (weight_ff[req_data.dest_vertex] == '1) begin
         chk_status = ST_DST_FULL;
      end else begin
         chk_status = ST_OK;
      end
   end

   // Recompute step: vertex k joins the running neighbor sums of cut cnt.
   always_comb begin
      k_idx      = step_ff[VertexBits-1:0];
      adj_k      = adj_row(adj_ff, k_idx);
      sides_k    = side_vec(cnt_ff[CutBits-1:0]);
      recalc_sum = acc_ff + CutSumBits'(prod_ff);
   end

   // Feasibility now and after the probed move.
   always_comb begin
      adj_i      = adj_row(adj_ff, src_ff);
      adj_j      = adj_row(adj_ff, dst_ff);
      feas_now   = 1'b0;
      feas_after = 1'b0;
      av         = '0;
      dv         = '0;
      for (int v = 0; v < VertexCount; v++) begin
         if (weight_ff[v] != '0 && nw_ff[v] <= bound_ff) begin
            feas_now = 1'b1;
         end
         av = 18'(weight_ff[v]) + 18'(dst_ff == VertexBits'(v))
              - 18'(src_ff == VertexBits'(v));
         dv = 22'(nw_ff[v]) + 22'(adj_j[v]) - 22'(adj_i[v]);
         if (av != '0 && !av[17] && (dv[21] || dv[20:0] <= 21'(bound_ff))) begin
            feas_after = 1'b1;
         end
      end
   end

   // Shared minimum tracker over the swept cuts.
   always_comb begin
      if (state_ff == S_RECALC) begin
         cand       = BestBits'(recalc_sum);
         first_cand = cnt_ff == '0;
      end else begin
         cand       = (cmd_ff == CMD_PROBE) ? walk_value : BestBits'(walk_row.cut_sum);
         first_cand = cnt_ff == (CutBits + 1)'(1);
      end
      take_cand = first_cand || ($signed(cand) < $signed(best_ff));
   end

   // Clamp the probed minimum into the field range.
   always_comb begin
      if (best_ff[BestBits-1]) begin
         probe_clamped = '0;
      end else if (best_ff[BestBits-2:CutSumBits] != '0) begin
         probe_clamped = '1;
      end else begin
         probe_clamped = best_ff[CutSumBits-1:0];
      end
   end

   always_comb begin
      state_in  = state_ff;
      weight_in = weight_ff;
      nw_in     = nw_ff;
      bound_in  = bound_ff;
      total_in  = total_ff;
      min_in    = min_ff;
      cmd_in    = cmd_ff;
      src_in    = src_ff;
      dst_in    = dst_ff;
      status_in = status_ff;
      cnt_in    = cnt_ff;
      step_in   = step_ff;
      acc_in    = acc_ff;
      prod_in   = prod_ff;
      msum_in   = msum_ff;
      best_in   = best_ff;
      wr_en     = 1'b0;
      wr_addr   = walk_cut;
      wr_row    = walk_row;
      sum_w     = '0;
      nw_acc    = '0;
      adj_v     = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               cmd_in    = req_data.cmd;
               src_in    = req_data.source_vertex;
               dst_in    = req_data.dest_vertex;
               status_in = ST_OK;
               cnt_in    = '0;
               case (req_data.cmd)
                  CMD_LOAD: begin
                     weight_in[req_data.source_vertex] = req_data.weight;
                     state_in = S_RESP;
                  end
                  CMD_RECALC: begin
                     // Total and weighted degrees come straight from the weights.
                     for (int v = 0; v < VertexCount; v++) begin
                        sum_w = sum_w + TotalBits'(weight_ff[v]);
                     end
                     total_in = SumBits'(sum_w);
                     for (int v = 0; v < VertexCount; v++) begin
                        nw_acc = '0;
                        adj_v  = adj_row(adj_ff, VertexBits'(v));
                        for (int u = 0; u < VertexCount; u++) begin
                           if (adj_v[u]) begin
                              nw_acc = nw_acc + SumBits'(weight_ff[u]);
                           end
                        end
                        nw_in[v] = nw_acc;
                     end
                     step_in  = '0;
                     msum_in  = '0;
                     state_in = S_DIV_START;
                  end
                  default: begin
                     status_in = chk_status;
                     state_in  = (chk_status == ST_OK) ? S_WALK : S_RESP;
                  end
               endcase
            end
         end
         S_DIV_START: begin
            state_in = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (div_done) begin
               bound_in = (div_quot[DivBits-1:SumBits] != '0) ? '1 : div_quot[SumBits-1:0];
               state_in = S_RECALC;
            end
         end
         S_RECALC: begin
            if (step_ff != 4'd8) begin
               // Multiply k's weight by its earlier same-side neighbors, then add k in.
               prod_in = 36'(weight_ff[k_idx]) * 36'(msum_ff[k_idx]);
               acc_in  = (step_ff == '0) ? '0 : recalc_sum;
               for (int u = 0; u < VertexCount; u++) begin
                  if (adj_k[u] && (sides_k[u] == sides_k[k_idx])) begin
                     msum_in[u] = msum_ff[u] + SumBits'(weight_ff[k_idx]);
                  end
               end
               step_in = step_ff + 4'd1;
            end else begin
               wr_en          = 1'b1;
               wr_addr        = cnt_ff[CutBits-1:0];
               wr_row.cut_sum = recalc_sum;
               wr_row.nsum    = msum_ff;
               if (take_cand) begin
                  best_in = cand;
               end
               msum_in = '0;
               step_in = '0;
               if (cnt_ff == (CutBits + 1)'(CutCount - 1)) begin
                  min_in   = best_in[CutSumBits-1:0];
                  state_in = S_RESP;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         S_WALK: begin
            // Read of cut cnt is in flight; row cnt-1 is at the unit.
            if (cnt_ff != '0) begin
               if (take_cand) begin
                  best_in = cand;
               end
               wr_en = cmd_ff == CMD_APPLY;
            end
            if (cnt_ff == (CutBits + 1)'(CutCount)) begin
               if (cmd_ff == CMD_APPLY) begin
                  min_in = best_in[CutSumBits-1:0];
                  weight_in[src_ff] = weight_ff[src_ff] - 1'b1;
                  weight_in[dst_ff] = weight_ff[dst_ff] + 1'b1;
                  for (int u = 0; u < VertexCount; u++) begin
                     nw_in[u] = nw_ff[u] - SumBits'(adj_i[u]) + SumBits'(adj_j[u]);
                  end
               end
               state_in = S_RESP;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_RESP: begin
            // Hold until the output register is free.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.min_cut       = min_ff;
               rsp_data_in.feasible      = feas_now;
               rsp_data_in.total_weight  = total_ff[TotalBits-1:0];
               rsp_data_in.status        = status_ff;
               if (cmd_ff == CMD_PROBE && status_ff == ST_OK) begin
                  rsp_data_in.probe_value   = probe_clamped;
                  rsp_data_in.move_feasible = feas_after;
               end else begin
                  rsp_data_in.probe_value   = '0;
                  rsp_data_in.move_feasible = 1'b0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      src_ff      <= src_in;
      dst_ff      <= dst_in;
      status_ff   <= status_in;
      cnt_ff      <= cnt_in;
      step_ff     <= step_in;
      acc_ff      <= acc_in;
      prod_ff     <= prod_in;
      msum_ff     <= msum_in;
      best_ff     <= best_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         adj_ff       <= '0;
         num_ff       <= RatioBits'(3);
         den_ff       <= RatioBits'(8);
         weight_ff    <= '0;
         nw_ff        <= '0;
         bound_ff     <= '0;
         total_ff     <= '0;
         min_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         weight_ff    <= weight_in;
         nw_ff        <= nw_in;
         bound_ff     <= bound_in;
         total_ff     <= total_in;
         min_ff       <= min_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ADJACENCY:   adj_ff <= csr_data;
               CSR_NUMERATOR:   num_ff <= csr_data[RatioBits-1:0];
               CSR_DENOMINATOR: den_ff <= csr_data[RatioBits-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
